// ===== src/uhm_pkg.sv =====
package uhm_pkg;

   // Field and register widths
   localparam int KEY_W         = 8;
   localparam int COEF_W        = 16;
   localparam int MOD_W         = 16;
   localparam int LEN_W         = 3;
   localparam int POS_W         = 3;
   localparam int SUM_W         = 19;
   localparam int MAX_KEY_BYTES = 6;
   localparam int NUM_COEFS     = MAX_KEY_BYTES;

   // Reduction unit: one quotient bit per step over the full product width
   localparam int RED_W     = KEY_W + COEF_W;
   localparam int RED_STEPS = RED_W;
   localparam int RED_CNT_W = $clog2(RED_STEPS + 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [MOD_W-1:0]  MODULUS_RESET = 16'd65521;
   localparam logic [LEN_W-1:0]  KEY_LEN_RESET = 3'd1;
   localparam logic [COEF_W-1:0] COEF_RESET    = 16'd1;

   typedef enum logic [2:0] {
      CSR_MODULUS    = 3'd0,
      CSR_KEY_LENGTH = 3'd1,
      CSR_COEF_0     = 3'd2,
      CSR_COEF_1     = 3'd3,
      CSR_COEF_2     = 3'd4,
      CSR_COEF_3     = 3'd5,
      CSR_COEF_4     = 3'd6,
      CSR_COEF_5     = 3'd7
   } csr_index_type;

   typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_array_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_byte;
      logic [COEF_W-1:0] coef;
      logic              last;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic             start;
      logic [RED_W-1:0] value;
   } red_ctrl_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_TERM,
      BK_SUM,
      BK_SUMWAIT,
      BK_OUT
   } back_state_type;

endpackage

// ===== src/uhm_queue.sv =====
module uhm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  uhm_pkg::queue_entry_type push_data,
   input  logic                     pop,
   output uhm_pkg::queue_entry_type head,
   output uhm_pkg::queue_status_type status
);
   import uhm_pkg::*;

   queue_entry_type        entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   // Pointer and fill count update, pointers wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/uhm_front.sv =====
module uhm_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [uhm_pkg::KEY_W-1:0]        req_key_byte,
   input  logic [uhm_pkg::LEN_W-1:0]        key_length,
   input  uhm_pkg::coef_array_type          coefs,
   input  uhm_pkg::queue_status_type        q_status,
   output logic                             q_push,
   output uhm_pkg::queue_entry_type         q_data
);
   import uhm_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] pos_clamped;
   logic [LEN_W-1:0] eff_len;
   logic             last;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   // Clamp position and length into the supported key range
   always_comb begin
      pos_clamped = (pos_ff > POS_W'(MAX_KEY_BYTES - 1)) ? POS_W'(MAX_KEY_BYTES - 1) : pos_ff;
      if (key_length == '0) begin
         eff_len = LEN_W'(1);
      end else if (key_length > LEN_W'(MAX_KEY_BYTES)) begin
         eff_len = LEN_W'(MAX_KEY_BYTES);
      end else begin
         eff_len = key_length;
      end
      last = (({1'b0, pos_clamped} + (POS_W + 1)'(1)) >= (POS_W + 1)'(eff_len));
   end

   // Tag the byte with its coefficient and whether it closes the key
   always_comb begin
      q_data.key_byte = req_key_byte;
      q_data.coef     = coefs[pos_clamped];
      q_data.last     = last;
      pos_in          = pos_ff;
      if (q_push) begin
         pos_in = last ? '0 : pos_clamped + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== src/uhm_reduce.sv =====
module uhm_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  uhm_pkg::red_ctrl_type       ctrl,
   input  logic [uhm_pkg::MOD_W-1:0]   modulus,
   output logic                        done,
   output logic [uhm_pkg::MOD_W-1:0]   result
);
   import uhm_pkg::*;

   // Restoring reduction, one dividend bit per cycle, MSB first
   logic [RED_W-1:0]     val_ff, val_in;
   logic [MOD_W:0]       rem_ff, rem_in;
   logic [RED_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_W:0]       trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[MOD_W-1:0], val_ff[RED_W-1]};
      if (ctrl.start) begin
         val_in  = ctrl.value;
         rem_in  = '0;
         cnt_in  = RED_CNT_W'(RED_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, modulus}) ? trial - {1'b0, modulus} : trial;
         val_in = {val_ff[RED_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == RED_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

   // A zero modulus reduces everything to zero
   assign done   = done_ff;
   assign result = (modulus == '0) ? '0 : rem_ff[MOD_W-1:0];

endmodule

// ===== src/uhm_back.sv =====
module uhm_back (
   input  logic                           clock,
   input  logic                           reset,
   input  uhm_pkg::queue_status_type      q_status,
   input  uhm_pkg::queue_entry_type       q_head,
   output logic                           q_pop,
   output uhm_pkg::red_ctrl_type          red_ctrl,
   input  logic                           red_done,
   input  logic [uhm_pkg::MOD_W-1:0]      red_result,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [uhm_pkg::MOD_W-1:0]      rsp_hash_value
);
   import uhm_pkg::*;

   back_state_type   state_ff, state_in;
   logic [RED_W-1:0] prod_ff, prod_in;
   logic             last_ff, last_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MOD_W-1:0] rsp_hash_ff, rsp_hash_in;

   // Sequencer: product, term reduction, accumulate; final reduction and output after a key's last byte
   always_comb begin
      state_in       = state_ff;
      prod_in        = prod_ff;
      last_in        = last_ff;
      sum_in         = sum_ff;
      rsp_hash_in    = rsp_hash_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      q_pop          = 1'b0;
      red_ctrl.start = 1'b0;
      red_ctrl.value = prod_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               prod_in  = RED_W'(q_head.coef) * RED_W'(q_head.key_byte);
               last_in  = q_head.last;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            red_ctrl.start = 1'b1;
            state_in       = BK_TERM;
         end
         BK_TERM: begin
            if (red_done) begin
               sum_in   = sum_ff + SUM_W'(red_result);
               state_in = last_ff ? BK_SUM : BK_IDLE;
            end
         end
         BK_SUM: begin
            red_ctrl.start = 1'b1;
            red_ctrl.value = RED_W'(sum_ff);
            state_in       = BK_SUMWAIT;
         end
         BK_SUMWAIT: begin
            if (red_done) begin
               sum_in   = '0;
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            // Result stays in the reduction unit until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = red_result;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

// ===== src/universal_hash_mod_prime.sv =====
// Universal hash of a key of up to six bytes, as a dot product modulo a
// programmable modulus. Key bytes enter one per transfer on the req channel;
// the last byte of each key (set by key_length) yields one hash on the rsp
// channel, earlier bytes yield nothing. The front end tags each byte with its
// coefficient and end-of-key flag and queues up to two bytes; the back end
// works them off with one shared bit-serial reduction unit: a byte is
// multiplied, reduced in 24 steps after a start, then accumulated; a key's
// last byte adds the final reduction of the sum and the output register load.
// The 24-step reduction sets the rate. The user must write registers through
// the APB port only while no byte is in flight; the block does not check.
module universal_hash_mod_prime (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [uhm_pkg::KEY_W-1:0]         req_key_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [uhm_pkg::MOD_W-1:0]         rsp_hash_value,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [uhm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [uhm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [uhm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import uhm_pkg::*;

   logic [MOD_W-1:0] modulus_ff, modulus_in;
   logic [LEN_W-1:0] key_len_ff, key_len_in;
   coef_array_type   coef_ff, coef_in;
   csr_index_type    csr_index;
   logic             csr_write;

   queue_status_type q_status;
   queue_entry_type  q_push_data, q_head;
   logic             q_push, q_pop;
   red_ctrl_type     red_ctrl;
   logic             red_done;
   logic [MOD_W-1:0] red_result;

   // Register file
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      modulus_in = modulus_ff;
      key_len_in = key_len_ff;
      coef_in    = coef_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MODULUS:    modulus_in = pwdata[MOD_W-1:0];
            CSR_KEY_LENGTH: key_len_in = pwdata[LEN_W-1:0];
            CSR_COEF_0:     coef_in[0] = pwdata[COEF_W-1:0];
            CSR_COEF_1:     coef_in[1] = pwdata[COEF_W-1:0];
            CSR_COEF_2:     coef_in[2] = pwdata[COEF_W-1:0];
            CSR_COEF_3:     coef_in[3] = pwdata[COEF_W-1:0];
            CSR_COEF_4:     coef_in[4] = pwdata[COEF_W-1:0];
            CSR_COEF_5:     coef_in[5] = pwdata[COEF_W-1:0];
            default:        modulus_in = modulus_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_index)
         CSR_MODULUS:    prdata = CSR_DATA_W'(modulus_ff);
         CSR_KEY_LENGTH: prdata = CSR_DATA_W'(key_len_ff);
         CSR_COEF_0:     prdata = CSR_DATA_W'(coef_ff[0]);
         CSR_COEF_1:     prdata = CSR_DATA_W'(coef_ff[1]);
         CSR_COEF_2:     prdata = CSR_DATA_W'(coef_ff[2]);
         CSR_COEF_3:     prdata = CSR_DATA_W'(coef_ff[3]);
         CSR_COEF_4:     prdata = CSR_DATA_W'(coef_ff[4]);
         CSR_COEF_5:     prdata = CSR_DATA_W'(coef_ff[5]);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         key_len_ff <= KEY_LEN_RESET;
         coef_ff    <= {NUM_COEFS{COEF_RESET}};
      end else begin
         modulus_ff <= modulus_in;
         key_len_ff <= key_len_in;
         coef_ff    <= coef_in;
      end
   end

   uhm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_key_byte (req_key_byte),
      .key_length   (key_len_ff),
      .coefs        (coef_ff),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_data       (q_push_data)
   );

   uhm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   uhm_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (red_ctrl),
      .modulus (modulus_ff),
      .done    (red_done),
      .result  (red_result)
   );

   uhm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .red_ctrl       (red_ctrl),
      .red_done       (red_done),
      .red_result     (red_result),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

// ===== src/uhm_checker.sv =====
module uhm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_hash_value
);

   // No result survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("stalled result changed");

   // A hash is below a nonzero modulus, which never exceeds 16'hFFFF, so it never equals 16'hFFFF
   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hash_value != 16'hFFFF)
      else $error("hash out of range");

endmodule

bind universal_hash_mod_prime uhm_checker u_checker (.*);

// ===== dv/universal_hash_mod_prime_tb.sv =====
module universal_hash_mod_prime_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uhm_pkg::*;

   localparam int IDLE_CYCLES   = 200;   // covers two queued bytes plus a final reduction
   localparam int LONG_HOLD     = 300;
   localparam int RAND_PHASES   = 12;
   localparam int BYTES_PER_PHASE = 125;
   localparam int NUM_ROWS      = 35;

   typedef enum logic {ROW_KEY, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type csr_idx;
      logic [15:0]   value;   // register value, or key byte in the low bits
      bit            typed;   // hash given in the row
      logic [15:0]   hash;
   } stim_row_type;

   // Directed stimulus
   stim_row_type dir_rows [NUM_ROWS] = '{
      // reset settings: modulus 65521, length 1, coefficients 1
      '{ROW_KEY, CSR_MODULUS,    16'd0,     1'b1, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd255,   1'b1, 16'd255},
      '{ROW_KEY, CSR_MODULUS,    16'd170,   1'b1, 16'd170},
      // modulus zero and one give zero
      '{ROW_CSR, CSR_MODULUS,    16'd0,     1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd255,   1'b1, 16'd0},
      '{ROW_CSR, CSR_MODULUS,    16'd1,     1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd200,   1'b1, 16'd0},
      // largest modulus, coefficient of minus one
      '{ROW_CSR, CSR_MODULUS,    16'd65535, 1'b0, 16'd0},
      '{ROW_CSR, CSR_COEF_0,     16'd65534, 1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd255,   1'b1, 16'd65280},
      // length zero acts as one
      '{ROW_CSR, CSR_KEY_LENGTH, 16'd0,     1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd1,     1'b1, 16'd65534},
      // length seven saturates to six, zero coefficients
      '{ROW_CSR, CSR_KEY_LENGTH, 16'd7,     1'b0, 16'd0},
      '{ROW_CSR, CSR_COEF_1,     16'd0,     1'b0, 16'd0},
      '{ROW_CSR, CSR_COEF_2,     16'd0,     1'b0, 16'd0},
      '{ROW_CSR, CSR_COEF_3,     16'd0,     1'b0, 16'd0},
      '{ROW_CSR, CSR_COEF_4,     16'd0,     1'b0, 16'd0},
      '{ROW_CSR, CSR_COEF_5,     16'd0,     1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd255,   1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd255,   1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd255,   1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd255,   1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd255,   1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd255,   1'b1, 16'd65280},
      // length lowered in the middle of a key
      '{ROW_CSR, CSR_COEF_1,     16'd12345, 1'b0, 16'd0},
      '{ROW_CSR, CSR_COEF_2,     16'd40000, 1'b0, 16'd0},
      '{ROW_CSR, CSR_COEF_3,     16'd65535, 1'b0, 16'd0},
      '{ROW_CSR, CSR_KEY_LENGTH, 16'd6,     1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd17,    1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd200,   1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd99,    1'b0, 16'd0},
      '{ROW_CSR, CSR_KEY_LENGTH, 16'd2,     1'b0, 16'd0},
      '{ROW_KEY, CSR_MODULUS,    16'd7,     1'b0, 16'd0},
      // length three and modulus 65521 set, no key bytes follow
      '{ROW_CSR, CSR_KEY_LENGTH, 16'd3,     1'b0, 16'd0},
      '{ROW_CSR, CSR_MODULUS,    16'd65521, 1'b0, 16'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KEY_W-1:0]      req_key_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [MOD_W-1:0]      rsp_hash_value;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Shadow registers and hash state
   logic [MOD_W-1:0]  modulus_sh;
   logic [LEN_W-1:0]  key_len_sh;
   logic [COEF_W-1:0] coef_sh [NUM_COEFS];
   logic [POS_W-1:0]  position_sh;
   logic [SUM_W-1:0]  sum_sh;

   logic [MOD_W-1:0]  hash_q [$];
   int                fail_count = 0;
   int                hash_count = 0;
   int                rx_wait;
   int                rx_left = 0;
   bit                rx_calm = 1'b0;
   bit                tx_calm = 1'b0;

   universal_hash_mod_prime u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_byte   (req_key_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Product of byte and coefficient, or a sum, reduced by the modulus
   function automatic logic [MOD_W-1:0] mod_reduce(input logic [RED_W-1:0] v);
      if (modulus_sh == '0) return '0;
      return MOD_W'(v % {{(RED_W-MOD_W){1'b0}}, modulus_sh});
   endfunction

   // Advance the hash by one key byte; done marks the end of a key
   task automatic hash_step(input logic [KEY_W-1:0] b, output bit done,
                            output logic [MOD_W-1:0] h);
      logic [POS_W-1:0]  p;
      logic [LEN_W-1:0]  n;
      logic [RED_W-1:0]  prod;
      p = (position_sh > POS_W'(NUM_COEFS - 1)) ? POS_W'(NUM_COEFS - 1) : position_sh;
      n = (key_len_sh == '0) ? LEN_W'(1) :
          (key_len_sh > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_len_sh;
      prod = RED_W'(coef_sh[p]) * RED_W'(b);
      sum_sh = sum_sh + SUM_W'(mod_reduce(prod));
      h = '0;
      done = (int'(p) + 1 >= int'(n));
      if (done) begin
         h = mod_reduce(RED_W'(sum_sh));
         position_sh = '0;
         sum_sh = '0;
      end else begin
         position_sh = p + POS_W'(1);
      end
   endtask

   // Offer one key byte, wait for the transfer, queue the hash it completes
   task automatic send_key_byte(input logic [KEY_W-1:0] b, input bit typed,
                                input logic [MOD_W-1:0] typed_hash);
      int               gap;
      bit               done;
      logic [MOD_W-1:0] h;
      if ($urandom_range(0, 31) == 0) tx_calm = ~tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_key_byte <= b;
      do @(posedge clock); while (req_stall);
      hash_step(b, done, h);
      if (typed) hash_q.push_back(typed_hash);
      else if (done) hash_q.push_back(h);
   endtask

   // Wait until every hash is out and the back end has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (hash_q.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access; unused upper data bits are random
   task automatic csr_write(input csr_index_type idx, input logic [15:0] val);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] data;
      wait_idle();
      mask = (idx == CSR_KEY_LENGTH) ? CSR_DATA_W'(3'h7) : CSR_DATA_W'(16'hFFFF);
      data = ($urandom & ~mask) | (CSR_DATA_W'(val) & mask);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_MODULUS:    modulus_sh = data[MOD_W-1:0];
         CSR_KEY_LENGTH: key_len_sh = data[LEN_W-1:0];
         default:        coef_sh[int'(idx) - int'(CSR_COEF_0)] = data[COEF_W-1:0];
      endcase
   endtask

   // Random value for a 16-bit register, biased toward the extremes
   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Receiver: check each transfer, draw the wait before the next one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hash_q.size() == 0) begin
            $error("unexpected hash_value transfer: actual %0d", rsp_hash_value);
            fail_count++;
         end else if (hash_q[0] !== rsp_hash_value) begin
            $error("hash_value mismatch: expected %0d, actual %0d",
                   hash_q[0], rsp_hash_value);
            fail_count++;
            void'(hash_q.pop_front());
         end else begin
            void'(hash_q.pop_front());
         end
         hash_count++;
         if ($urandom_range(0, 31) == 0) rx_calm = ~rx_calm;
         if (hash_count % 128 == 64) rx_wait = LONG_HOLD;
         else rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
      end else begin
         rx_wait = (rx_left == 0) ? 0 : rx_left - 1;
      end
      rx_left   <= rx_wait;
      rsp_stall <= (rx_wait != 0);
   end

   // Stimulus
   initial begin
      logic [15:0] m;
      logic [7:0]  b;
      modulus_sh  = MODULUS_RESET;
      key_len_sh  = KEY_LEN_RESET;
      for (int i = 0; i < NUM_COEFS; i++) coef_sh[i] = COEF_RESET;
      position_sh = '0;
      sum_sh      = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR)
            csr_write(dir_rows[i].csr_idx, dir_rows[i].value);
         else
            send_key_byte(dir_rows[i].value[KEY_W-1:0], dir_rows[i].typed, dir_rows[i].hash);
      end

      // random phases; a new setting may land in the middle of a key
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(0, 7))
            0:       m = 16'd2;
            1:       m = 16'hFFFF;
            2:       m = 16'd65521;
            3:       m = 16'($urandom_range(0, 1));
            default: m = 16'($urandom_range(2, 65535));
         endcase
         csr_write(CSR_MODULUS, m);
         for (int c = 0; c < NUM_COEFS; c++)
            csr_write(csr_index_type'(int'(CSR_COEF_0) + c), pick_coef());
         csr_write(CSR_KEY_LENGTH, ($urandom_range(0, 5) == 0) ?
                   16'($urandom_range(0, 7)) : 16'($urandom_range(1, 6)));
         for (int k = 0; k < BYTES_PER_PHASE; k++) begin
            case ($urandom_range(0, 7))
               0:       b = 8'd0;
               1:       b = 8'hFF;
               default: b = 8'($urandom);
            endcase
            send_key_byte(b, 1'b0, '0);
         end
      end

      // drain and report
      wait_idle();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
